>>> design/tpsg_pkg.sv
`default_nettype none

package tpsg_pkg;

	// parameter defaults
	localparam int HEADER_BYTES_DEF = 768;
	localparam int MIN_PAYLOAD_DEF  = 32;
	localparam int DASH_SEARCH_DEF  = 8;

	// byte counter saturates at 1023 with a separate full flag
	localparam int POS_W = 10;

	localparam logic [2:0] V_KEEP      = 3'd0;
	localparam logic [2:0] V_DROP      = 3'd1;
	localparam logic [2:0] V_UNDECIDED = 3'd2;
	localparam logic [2:0] V_NOT_HEAD  = 3'd3;
	localparam logic [2:0] V_SHORT     = 3'd4;
	localparam logic [2:0] V_UNGATED   = 3'd5;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       first_byte;
		logic       last_byte;
		logic [7:0] sample_percent;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [63:0] trace_hash;
	} out_item_t;

	// per-byte control from the framing logic to the parser
	typedef struct packed {
		logic step;      // byte consumed this cycle
		logic start;     // byte opens a new packet
		logic parse_en;  // byte lies inside the header window
		logic last;      // byte closes the packet
	} parse_ctl_t;

endpackage

`default_nettype wire

>>> design/tpsg_stream_if.sv
`default_nettype none

interface tpsg_stream_if #(
	parameter type payload_t = logic [0:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/tpsg_parse.sv
`default_nettype none

// traceparent matcher and FNV-1a-64 over the decoded trace id
module tpsg_parse #(
	parameter int DASH_SEARCH = tpsg_pkg::DASH_SEARCH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tpsg_pkg::parse_ctl_t ctl,
	input  wire logic [7:0]           octet,
	input  wire logic [7:0]           percent,
	output logic [2:0]                result_next,
	output logic [63:0]               hash
);

	localparam logic [2:0] PH_NEWLINE = 3'd0;
	localparam logic [2:0] PH_NAME    = 3'd1;
	localparam logic [2:0] PH_DASH    = 3'd2;
	localparam logic [2:0] PH_HEX     = 3'd3;
	localparam logic [2:0] PH_TERM    = 3'd4;
	localparam logic [2:0] PH_DONE    = 3'd5;

	localparam logic [63:0] FNV_OFFSET = 64'hcbf2_9ce4_8422_2325;
	localparam logic [5:0]  DashLim    = 6'(DASH_SEARCH);
	localparam logic [5:0]  HexDigits  = 6'd32;
	localparam logic [3:0]  NameLast   = 4'd11;
	localparam logic [7:0]  LF         = 8'h0a;
	localparam logic [7:0]  DASH       = 8'h2d;

	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= 8'h30 && c <= 8'h39)
			v = 5'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66)
			v = 5'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46)
			v = 5'(c - 8'h37);
		return v;
	endfunction

	// "traceparent:"
	function automatic logic [7:0] name_char(input logic [3:0] idx);
		logic [7:0] ch;
		unique case (idx)
			4'd0:    ch = 8'h74;
			4'd1:    ch = 8'h72;
			4'd2:    ch = 8'h61;
			4'd3:    ch = 8'h63;
			4'd4:    ch = 8'h65;
			4'd5:    ch = 8'h70;
			4'd6:    ch = 8'h61;
			4'd7:    ch = 8'h72;
			4'd8:    ch = 8'h65;
			4'd9:    ch = 8'h6e;
			4'd10:   ch = 8'h74;
			4'd11:   ch = 8'h3a;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// (h ^ o) * 0x100000001b3 as shifts and adds: 2^40 + 0x1b3
	function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] o);
		logic [63:0] x;
		x = h ^ {56'd0, o};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	logic [2:0]  phase_q, phase_e, phase_n;
	logic [5:0]  index_q, index_e, index_n, index_inc;
	logic [3:0]  nibble_q, nibble_e, nibble_n;
	logic [63:0] hash_q, hash_e, hash_n, hash_mix;
	logic [2:0]  result_q, result_e, result_n;
	logic [4:0]  digit;
	logic [7:0]  name_ch;
	logic        name_hit;
	logic [14:0] lhs;
	logic [15:0] rhs;

	always_comb begin
		phase_e  = ctl.start ? PH_NEWLINE : phase_q;
		index_e  = ctl.start ? 6'd0 : index_q;
		nibble_e = ctl.start ? 4'd0 : nibble_q;
		hash_e   = ctl.start ? FNV_OFFSET : hash_q;
		result_e = ctl.start ? tpsg_pkg::V_UNDECIDED : result_q;

		digit     = hex_value(octet);
		name_ch   = name_char(index_e[3:0]);
		index_inc = index_e + 6'd1;
		hash_mix  = fnv_mix(hash_e, {nibble_e, digit[3:0]});
		name_hit  = (index_e[3:0] < NameLast) ? ((octet | 8'h20) == name_ch)
		                                      : (octet == name_ch);
		lhs = {7'd0, hash_e[7:0]} * 15'd100;
		rhs = {percent, 8'd0};

		phase_n  = phase_e;
		index_n  = index_e;
		nibble_n = nibble_e;
		hash_n   = hash_e;
		result_n = result_e;

		if (ctl.parse_en) begin
			unique case (phase_e)
				PH_NEWLINE: begin
					if (octet == LF) begin
						phase_n = PH_NAME;
						index_n = 6'd0;
					end
				end
				PH_NAME: begin
					if (name_hit) begin
						if (index_e[3:0] == NameLast) begin
							phase_n = PH_DASH;
							index_n = 6'd0;
						end else begin
							index_n = {2'd0, index_inc[3:0]};
						end
					end else begin
						phase_n = (octet == LF) ? PH_NAME : PH_NEWLINE;
						index_n = 6'd0;
					end
				end
				PH_DASH: begin
					if (octet == DASH) begin
						phase_n = PH_HEX;
						index_n = 6'd0;
					end else begin
						index_n = index_inc;
						if (index_inc >= DashLim)
							phase_n = PH_DONE;
					end
				end
				PH_HEX: begin
					if (digit[4]) begin
						phase_n = PH_DONE;
					end else begin
						if (!index_e[0])
							nibble_n = digit[3:0];
						else
							hash_n = hash_mix;
						index_n = index_inc;
						if (index_inc >= HexDigits) begin
							phase_n = PH_TERM;
							index_n = 6'd0;
						end
					end
				end
				PH_TERM: begin
					if (octet == DASH)
						result_n = ({1'b0, lhs} < rhs) ? tpsg_pkg::V_KEEP : tpsg_pkg::V_DROP;
					phase_n = PH_DONE;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_NEWLINE;
			index_q  <= 6'd0;
			nibble_q <= 4'd0;
			hash_q   <= FNV_OFFSET;
			result_q <= tpsg_pkg::V_UNDECIDED;
		end else if (ctl.step) begin
			if (ctl.last) begin
				phase_q  <= PH_NEWLINE;
				index_q  <= 6'd0;
				nibble_q <= 4'd0;
				hash_q   <= FNV_OFFSET;
				result_q <= tpsg_pkg::V_UNDECIDED;
			end else begin
				phase_q  <= phase_n;
				index_q  <= index_n;
				nibble_q <= nibble_n;
				hash_q   <= hash_n;
				result_q <= result_n;
			end
		end
	end

	assign result_next = result_n;
	// a keep/drop verdict is only ever set after the last digit, so the
	// registered hash is already final when it is reported
	assign hash = hash_q;

endmodule

`default_nettype wire

>>> design/traceparent_sample_gate.sv
// Sampling gate for HTTP requests carrying a W3C traceparent header. TCP payload
// arrives one byte per request on the payload channel, with first_byte/last_byte
// framing and the packet's sample percentage (taken from the packet's first
// byte). Each last byte yields one request on the result channel: a verdict
// (keep, drop, undecided, not request head, too short, not gated) and the
// FNV-1a-64 hash of the 16-byte trace id, zero unless keep or drop. A packet is
// kept when (hash & 0xff) * 100 < percent * 256. Throughput is one byte per
// clock while the result side keeps up; any byte waits while an untaken result
// sits in the result register. The byte passes an input register, is parsed
// and hashed combinationally, and the verdict lands in the result register when
// the last byte leaves the input register, and is offered there until taken.
// The critical path is the FNV step, a constant multiply done as shifts and
// adds. No reset sweep; the block accepts bytes from the first cycle after
// reset. A first_byte mark mid-packet drops the partial packet silently.
`default_nettype none

module traceparent_sample_gate #(
	parameter int HEADER_BYTES = tpsg_pkg::HEADER_BYTES_DEF,
	parameter int MIN_PAYLOAD  = tpsg_pkg::MIN_PAYLOAD_DEF,
	parameter int DASH_SEARCH  = tpsg_pkg::DASH_SEARCH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tpsg_stream_if.sink   payload,
	tpsg_stream_if.source result
);

	localparam logic [10:0] HdrLim = 11'(HEADER_BYTES);
	localparam logic [10:0] MinLen = 11'(MIN_PAYLOAD);
	localparam logic [7:0]  PctMax = 8'd100;

	// any of GET, PUT, POST, HEAD, PATCH, DELETE, OPTIONS followed by a space;
	// byte k of the head sits in bits 8k+7..8k
	function automatic logic method_ok(input logic [63:0] h);
		return (h[31:0] == 32'h2054_4547)
		    || (h[31:0] == 32'h2054_5550)
		    || (h[39:0] == 40'h20_5453_4f50)
		    || (h[39:0] == 40'h20_4441_4548)
		    || (h[47:0] == 48'h2048_4354_4150)
		    || (h[55:0] == 56'h20_4554_454c_4544)
		    || (h[63:0] == 64'h2053_4e4f_4954_504f);
	endfunction

	// input register
	tpsg_pkg::in_item_t data_s1;
	logic               valid_s1;
	logic               adv;

	// result register
	tpsg_pkg::out_item_t out_q;
	logic                out_valid_q;

	// packet framing state
	logic [tpsg_pkg::POS_W-1:0] pos_q, pos_e, pos_n;
	logic                       full_q, full_e, full_n;
	logic [63:0]                head_q, head_e, head_n;
	logic [7:0]                 pct_q, pct_e;
	logic [10:0]                length;

	tpsg_pkg::parse_ctl_t ctl;
	logic [2:0]           parse_result;
	logic [63:0]          parse_hash;
	logic [2:0]           verdict;

	// a byte moves on whenever the result slot is free or being emptied
	assign adv           = valid_s1 && (!out_valid_q || result.ready);
	assign payload.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (payload.valid && payload.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (payload.valid && payload.ready)
			data_s1 <= payload.data;
	end

	// state as seen by this byte: a first mark restarts the packet
	always_comb begin
		pos_e  = data_s1.first_byte ? '0 : pos_q;
		full_e = data_s1.first_byte ? 1'b0 : full_q;
		head_e = data_s1.first_byte ? 64'd0 : head_q;
		pct_e  = data_s1.first_byte ? 8'd0 : pct_q;
		if (pos_e == '0 && !full_e)
			pct_e = data_s1.sample_percent;

		head_n = head_e;
		if (!full_e && pos_e < tpsg_pkg::POS_W'(8))
			head_n[8 * pos_e[2:0] +: 8] = data_s1.payload_byte;

		if (pos_e == '1) begin
			pos_n  = pos_e;
			full_n = 1'b1;
		end else begin
			pos_n  = pos_e + tpsg_pkg::POS_W'(1);
			full_n = full_e;
		end
		length = full_n ? 11'd1024 : {1'b0, pos_n};
	end

	always_comb begin
		ctl.step     = adv;
		ctl.start    = data_s1.first_byte;
		ctl.parse_en = !full_e && ({1'b0, pos_e} < HdrLim);
		ctl.last     = data_s1.last_byte;
	end

	tpsg_parse #(
		.DASH_SEARCH(DASH_SEARCH)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.octet       (data_s1.payload_byte),
		.percent     (pct_e),
		.result_next (parse_result),
		.hash        (parse_hash)
	);

	// verdict precedence: ungated, short, not a request head, parse outcome
	always_comb begin
		if (pct_e == 8'd0 || pct_e >= PctMax)
			verdict = tpsg_pkg::V_UNGATED;
		else if (length < MinLen || length < 11'd8)
			verdict = tpsg_pkg::V_SHORT;
		else if (!method_ok(head_n))
			verdict = tpsg_pkg::V_NOT_HEAD;
		else
			verdict = parse_result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			full_q <= 1'b0;
			head_q <= 64'd0;
			pct_q  <= 8'd0;
		end else if (adv) begin
			if (data_s1.last_byte) begin
				pos_q  <= '0;
				full_q <= 1'b0;
				head_q <= 64'd0;
				pct_q  <= 8'd0;
			end else begin
				pos_q  <= pos_n;
				full_q <= full_n;
				head_q <= head_n;
				pct_q  <= pct_e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && data_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && data_s1.last_byte) begin
			out_q.verdict    <= verdict;
			out_q.trace_hash <= (verdict == tpsg_pkg::V_KEEP || verdict == tpsg_pkg::V_DROP)
			                    ? parse_hash : 64'd0;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// verdict codes stop at not gated
	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.verdict <= tpsg_pkg::V_UNGATED))
		else $error("verdict code out of range");

	// hash only accompanies keep or drop
	a_hash_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !(out_q.verdict == tpsg_pkg::V_KEEP || out_q.verdict == tpsg_pkg::V_DROP)
		|-> (out_q.trace_hash == 64'd0))
		else $error("hash present without keep or drop");

	// a consumed last byte always leaves a result behind
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && data_s1.last_byte |=> out_valid_q)
		else $error("last byte produced no result");

	// framing state is cleared after a last byte
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && data_s1.last_byte |=> (pos_q == '0 && !full_q && pct_q == 8'd0))
		else $error("packet state not cleared after last byte");

endmodule

`default_nettype wire

>>> bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] octet_t;

	// where the header scan stands within the current packet
	typedef enum logic [2:0] {
		SEEK_LF,
		SEEK_NAME,
		SEEK_DASH,
		TAKE_HEX,
		SEEK_TERM,
		SCAN_DONE
	} scan_phase_t;

	// ways of spoiling the traceparent line of a generated request
	typedef enum {
		FLT_NONE,
		FLT_NO_TAG,
		FLT_NO_COLON,
		FLT_BAD_HEX,
		FLT_BAD_TERM
	} id_fault_t;

	localparam int WINDOW = tpsg_pkg::HEADER_BYTES_DEF;
	localparam int MIN_LEN = tpsg_pkg::MIN_PAYLOAD_DEF;
	localparam int DASH_REACH = tpsg_pkg::DASH_SEARCH_DEF;
	localparam logic [63:0] HASH_SEED = 64'hcbf29ce484222325;
	localparam logic [63:0] HASH_MUL = 64'h00000100000001b3;
	localparam octet_t LF = 8'h0a;
	localparam int STALL_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tpsg_stream_if #(.payload_t(tpsg_pkg::in_item_t)) payload_ch ();
	tpsg_stream_if #(.payload_t(tpsg_pkg::out_item_t)) result_ch ();

	traceparent_sample_gate i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.payload(payload_ch),
		.result(result_ch)
	);

	always #5 clk = ~clk;

	// method table, shared by the head check and the request builder
	string good_methods[7] = '{"GET ", "PUT ", "POST ", "HEAD ", "PATCH ", "DELETE ", "OPTIONS "};
	string bad_methods[5] = '{"GEt ", "get ", "GETX ", "POST/", "OPTIONSX"};
	string field_tag = "traceparent:";

	// verdicts still owed by the block, oldest first
	tpsg_pkg::out_item_t expected_verdicts[$];

	// packet under construction for the sender
	octet_t pkt[$];
	int term_at;

	int fail_count = 0;
	int bytes_sent = 0;

	// idling control: no_idle gives gap-free stretches on both sides,
	// rx_hold freezes the result side outright
	logic no_idle = 1'b0;
	logic rx_hold = 1'b0;
	int rx_wait = 0;

	// ---------------------------------------------------------------
	// Gate predictor: per-packet scan state
	// ---------------------------------------------------------------
	int unsigned seen;
	bit seen_full;
	logic [63:0] head;
	scan_phase_t phase;
	int unsigned idx;
	logic [3:0] hi_nib;
	logic [63:0] id_hash;
	octet_t pkt_pct;
	logic [2:0] parse_v;

	function automatic void clear_packet_state();
		seen = 0;
		seen_full = 1'b0;
		head = '0;
		phase = SEEK_LF;
		idx = 0;
		hi_nib = '0;
		id_hash = HASH_SEED;
		pkt_pct = '0;
		parse_v = tpsg_pkg::V_UNDECIDED;
	endfunction

	// 0..15 for a hex digit, 16 for anything else
	function automatic logic [4:0] hex_value(input octet_t c);
		if (c >= "0" && c <= "9")
			return 5'(c - "0");
		if (c >= "a" && c <= "f")
			return 5'(c - "a" + 10);
		if (c >= "A" && c <= "F")
			return 5'(c - "A" + 10);
		return 5'd16;
	endfunction

	// Advances the scan by one accepted byte; on the last byte works out
	// the verdict and queues it.
	task automatic predict_verdict(input tpsg_pkg::in_item_t it);
		octet_t b;
		logic [4:0] nib;
		int unsigned span;
		bit head_ok;
		bit hit;
		tpsg_pkg::out_item_t res;
		b = it.payload_byte;
		if (it.first_byte)
			clear_packet_state();
		if (seen == 0 && !seen_full)
			pkt_pct = it.sample_percent;

		if (!seen_full && seen < WINDOW) begin
			if (seen < 8)
				head[8*seen +: 8] = b;
			case (phase)
				SEEK_LF: begin
					if (b == LF) begin
						phase = SEEK_NAME;
						idx = 0;
					end
				end
				SEEK_NAME: begin
					// letters fold case, the colon must be exact
					hit = (idx < 11) ? ((b | 8'h20) == octet_t'(field_tag[idx]))
						: (b == octet_t'(field_tag[idx]));
					if (hit) begin
						if (idx == 11) begin
							phase = SEEK_DASH;
							idx = 0;
						end else begin
							idx++;
						end
					end else begin
						// a newline restarts the name match in place
						phase = (b == LF) ? SEEK_NAME : SEEK_LF;
						idx = 0;
					end
				end
				SEEK_DASH: begin
					if (b == "-") begin
						phase = TAKE_HEX;
						idx = 0;
					end else begin
						idx++;
						if (idx >= DASH_REACH)
							phase = SCAN_DONE;
					end
				end
				TAKE_HEX: begin
					nib = hex_value(b);
					if (nib[4]) begin
						phase = SCAN_DONE;
					end else begin
						if (idx % 2 == 0) begin
							hi_nib = nib[3:0];
						end else begin
							id_hash ^= {56'd0, hi_nib, nib[3:0]};
							id_hash = id_hash * HASH_MUL;
						end
						idx++;
						if (idx >= 32) begin
							phase = SEEK_TERM;
							idx = 0;
						end
					end
				end
				SEEK_TERM: begin
					if (b == "-")
						parse_v = (int'(id_hash[7:0]) * 100 < int'(pkt_pct) * 256)
							? tpsg_pkg::V_KEEP : tpsg_pkg::V_DROP;
					phase = SCAN_DONE;
				end
				default: ;
			endcase
		end

		// counter saturates; length checks then see 1024
		if (seen >= 1023)
			seen_full = 1'b1;
		else
			seen++;

		if (it.last_byte) begin
			span = seen_full ? 1024 : seen;
			head_ok = 1'b0;
			for (int m = 0; m < 7; m++) begin
				hit = 1'b1;
				for (int k = 0; k < good_methods[m].len(); k++)
					if (head[8*k +: 8] != octet_t'(good_methods[m][k]))
						hit = 1'b0;
				if (hit)
					head_ok = 1'b1;
			end
			if (pkt_pct == 0 || pkt_pct >= 100)
				res.verdict = tpsg_pkg::V_UNGATED;
			else if (span < MIN_LEN || span < 8)
				res.verdict = tpsg_pkg::V_SHORT;
			else if (!head_ok)
				res.verdict = tpsg_pkg::V_NOT_HEAD;
			else
				res.verdict = parse_v;
			res.trace_hash = (res.verdict == tpsg_pkg::V_KEEP
				|| res.verdict == tpsg_pkg::V_DROP) ? id_hash : 64'd0;
			expected_verdicts.push_back(res);
			clear_packet_state();
		end
	endtask

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		fail_count++;
		$display("%0t: %s: got %h, want %h", $time, what, got, want);
	endtask

	// Takes each result request, compares it with the oldest verdict owed,
	// and paces ready: a random wait after each request, none during the
	// gap-free stretches, low throughout a hold.
	always @(posedge clk) begin : result_check
		tpsg_pkg::out_item_t due;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch("result with none pending", {61'd0, result_ch.data.verdict},
						64'd0);
				end else begin
					due = expected_verdicts.pop_front();
					if (result_ch.data.verdict !== due.verdict)
						report_mismatch("verdict", {61'd0, result_ch.data.verdict},
							{61'd0, due.verdict});
					if (result_ch.data.trace_hash !== due.trace_hash)
						report_mismatch("trace_hash", result_ch.data.trace_hash,
							due.trace_hash);
				end
			end
			if (rx_hold) begin
				result_ch.ready <= 1'b0;
			end else if (!result_ch.ready || result_ch.valid) begin
				if (result_ch.ready)
					rx_wait = no_idle ? 0 : $urandom_range(0, 10);
				else if (rx_wait > 0)
					rx_wait--;
				result_ch.ready <= (rx_wait == 0);
			end
		end else begin
			result_ch.ready <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Sending
	// ---------------------------------------------------------------

	// Offers one byte after a random gap and returns at the edge where it
	// is taken; valid stays high so a following byte can go straight out.
	task automatic send_byte(input octet_t b, input bit first, input bit last,
			input octet_t pct);
		int gap;
		tpsg_pkg::in_item_t it;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		it.payload_byte = b;
		it.first_byte = first;
		it.last_byte = last;
		it.sample_percent = pct;
		if (gap > 0) begin
			payload_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		payload_ch.valid <= 1'b1;
		payload_ch.data <= it;
		do @(posedge clk); while (!payload_ch.ready);
		predict_verdict(it);
		bytes_sent++;
	endtask

	// Sends pkt; the percentage counts only on the opening byte, the rest
	// carry random values that the block must ignore.
	task automatic send_packet(input octet_t pct, input bit mark_first, input bit mark_last);
		for (int k = 0; k < pkt.size(); k++)
			send_byte(pkt[k], mark_first && k == 0, mark_last && k == pkt.size() - 1,
				(k == 0) ? pct : octet_t'($urandom_range(0, 255)));
	endtask

	// Drops valid and waits until every owed verdict has been taken.
	task automatic pause_for_results();
		payload_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_verdicts.size() != 0);
	endtask

	function automatic void put_text(input string s);
		for (int k = 0; k < s.len(); k++)
			pkt.push_back(octet_t'(s[k]));
	endfunction

	function automatic octet_t pick_percent();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return octet_t'($urandom_range(100, 255));
			2: return $urandom_range(0, 1) ? 8'd1 : 8'd99;
			default: return octet_t'($urandom_range(1, 99));
		endcase
	endfunction

	// Builds an HTTP request head with a traceparent line into pkt.
	// dash_gap bytes sit between colon and the dash that opens the id;
	// term_at records where the closing dash lands.
	task automatic build_request(input string meth, input int dash_gap,
			input id_fault_t fault, input int tail_len);
		string tag;
		octet_t ch;
		int nib;
		int bad_pos;
		pkt.delete();
		put_text(meth);
		put_text("/v1/items HTTP/1.1\n");
		// a broken-off name or a blank line keeps the name search armed
		if ($urandom_range(0, 3) == 0)
			put_text("tra\n");
		if ($urandom_range(0, 3) == 0)
			pkt.push_back(LF);
		tag = (fault == FLT_NO_TAG) ? "traceparnet" : "traceparent";
		for (int k = 0; k < tag.len(); k++)
			pkt.push_back($urandom_range(0, 1) ? octet_t'(tag[k]) : octet_t'(tag[k]) & 8'hdf);
		pkt.push_back((fault == FLT_NO_COLON) ? " " : ":");
		repeat (dash_gap) pkt.push_back($urandom_range(0, 1) ? "0" : " ");
		pkt.push_back("-");
		bad_pos = $urandom_range(0, 31);
		for (int k = 0; k < 32; k++) begin
			nib = $urandom_range(0, 15);
			ch = (nib < 10) ? octet_t'("0" + nib) : octet_t'("a" + nib - 10);
			if (nib >= 10 && $urandom_range(0, 1))
				ch = ch & 8'hdf;
			// neighbours of the digit ranges
			if (fault == FLT_BAD_HEX && k == bad_pos) begin
				case ($urandom_range(0, 5))
					0: ch = 8'h2f;
					1: ch = 8'h3a;
					2: ch = 8'h40;
					3: ch = 8'h47;
					4: ch = 8'h60;
					default: ch = 8'h67;
				endcase
			end
			pkt.push_back(ch);
		end
		term_at = pkt.size();
		pkt.push_back((fault == FLT_BAD_TERM) ? "_" : "-");
		put_text("01\n\n");
		repeat (tail_len) pkt.push_back(octet_t'($urandom_range(0, 255)));
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	task automatic test_framing();
		// first packet after reset carries no first mark
		build_request("GET ", 3, FLT_NONE, 12);
		send_packet(8'd50, 1'b0, 1'b1);
		// first mark mid-packet: the partial request vanishes without a verdict
		build_request("PUT ", 3, FLT_NONE, 0);
		pkt = pkt[0:19];
		send_packet(8'd40, 1'b1, 1'b0);
		build_request("PATCH ", 3, FLT_NONE, 5);
		send_packet(8'd60, 1'b1, 1'b1);
		// lone byte, a seven-byte packet, then either side of the length floor
		pkt.delete();
		pkt.push_back("G");
		send_packet(8'd50, 1'b1, 1'b1);
		pkt.delete();
		put_text("GET /ab");
		send_packet(8'd30, 1'b1, 1'b1);
		for (int n = MIN_LEN - 1; n <= MIN_LEN; n++) begin
			pkt.delete();
			put_text("GET ");
			while (pkt.size() < n)
				pkt.push_back("a");
			send_packet(8'd50, 1'b1, 1'b1);
		end
	endtask

	task automatic test_percent_limits();
		octet_t pcts[5] = '{8'd0, 8'd1, 8'd99, 8'd100, 8'd255};
		foreach (pcts[k]) begin
			build_request("POST ", 3, FLT_NONE, 4);
			send_packet(pcts[k], 1'b1, 1'b1);
		end
	endtask

	task automatic test_methods();
		foreach (good_methods[m]) begin
			build_request(good_methods[m], 3, FLT_NONE, 2);
			send_packet(8'd50, 1'b1, 1'b1);
		end
		foreach (bad_methods[m]) begin
			build_request(bad_methods[m], 3, FLT_NONE, 2);
			send_packet(8'd50, 1'b1, 1'b1);
		end
	endtask

	task automatic test_id_faults();
		// last dash position still searched, then the first one past it
		build_request("GET ", DASH_REACH - 1, FLT_NONE, 3);
		send_packet(8'd50, 1'b1, 1'b1);
		build_request("GET ", DASH_REACH, FLT_NONE, 3);
		send_packet(8'd50, 1'b1, 1'b1);
		build_request("GET ", 0, FLT_NO_TAG, 3);
		send_packet(8'd50, 1'b1, 1'b1);
		build_request("GET ", 3, FLT_NO_COLON, 3);
		send_packet(8'd50, 1'b1, 1'b1);
		build_request("GET ", 3, FLT_BAD_HEX, 3);
		send_packet(8'd50, 1'b1, 1'b1);
		build_request("GET ", 3, FLT_BAD_TERM, 3);
		send_packet(8'd50, 1'b1, 1'b1);
	endtask

	// Closing dash on the last byte inside the header window, then on the
	// first byte beyond it; padding goes into the request target.
	task automatic test_window_edge();
		int shift;
		for (int want = WINDOW - 1; want <= WINDOW; want++) begin
			build_request("GET ", 3, FLT_NONE, 8);
			shift = want - term_at;
			repeat (shift) pkt.insert(4, "z");
			send_packet(8'd50, 1'b1, 1'b1);
		end
	endtask

	// Packets long enough to saturate the byte counter.
	task automatic test_long_packets();
		int sizes[2] = '{1024, 1100};
		foreach (sizes[k]) begin
			build_request("DELETE ", 2, FLT_NONE, 0);
			while (pkt.size() < sizes[k])
				pkt.push_back(octet_t'($urandom_range(0, 255)));
			send_packet(8'd70, 1'b1, 1'b1);
		end
	endtask

	// Result side held off for a long stretch while short packets keep
	// coming, so the block backs up and stalls its input; then the sender
	// waits for everything owed.
	task automatic test_result_stall();
		no_idle <= 1'b1;
		fork
			begin
				rx_hold <= 1'b1;
				repeat (STALL_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		repeat (40) begin
			pkt.delete();
			repeat ($urandom_range(1, 4))
				pkt.push_back(octet_t'($urandom_range(0, 255)));
			send_packet(pick_percent(), 1'b1, 1'b1);
		end
		no_idle <= 1'b0;
		pause_for_results();
	endtask

	// Mostly well-formed requests with random content and the odd fault,
	// the rest raw bytes with loose framing.
	task automatic test_random_traffic();
		int start_bytes;
		int gap;
		string meth;
		id_fault_t fault;
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < 750) begin
			if ($urandom_range(0, 4) == 0)
				no_idle <= ~no_idle;
			if ($urandom_range(0, 9) < 7) begin
				meth = ($urandom_range(0, 9) == 0) ? bad_methods[$urandom_range(0, 4)]
					: good_methods[$urandom_range(0, 6)];
				case ($urandom_range(0, 11))
					0: fault = FLT_NO_TAG;
					1: fault = FLT_NO_COLON;
					2: fault = FLT_BAD_HEX;
					3: fault = FLT_BAD_TERM;
					default: fault = FLT_NONE;
				endcase
				gap = ($urandom_range(0, 9) == 0)
					? $urandom_range(DASH_REACH, DASH_REACH + 2)
					: $urandom_range(0, DASH_REACH - 1);
				build_request(meth, gap, fault, $urandom_range(0, 40));
				// now and then push the traceparent line around the window end
				if ($urandom_range(0, 29) == 0)
					repeat ($urandom_range(690, 760)) pkt.insert(4, "z");
				send_packet(pick_percent(), $urandom_range(0, 7) != 0, 1'b1);
			end else begin
				pkt.delete();
				if ($urandom_range(0, 2) == 0)
					put_text(good_methods[$urandom_range(0, 6)]);
				repeat ($urandom_range(1, 40))
					pkt.push_back(octet_t'($urandom_range(0, 255)));
				send_packet(pick_percent(), $urandom_range(0, 1) != 0,
					$urandom_range(0, 4) != 0);
			end
		end
		no_idle <= 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		payload_ch.valid <= 1'b0;
		payload_ch.data <= '0;
		clear_packet_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_framing();
		test_percent_limits();
		test_methods();
		test_id_faults();
		test_window_edge();
		test_long_packets();
		test_result_stall();
		test_random_traffic();

		pause_for_results();
		// a verdict is offered from the result register after its last byte; allow stragglers
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> filelist.f
design/tpsg_pkg.sv
design/tpsg_stream_if.sv
design/tpsg_parse.sv
design/traceparent_sample_gate.sv
bench/testbench.sv
